/* rtl/core/sbh_pkg.sv */
// Shared types, constants and round functions for the SHA-256 block hasher.
// Depends on nothing; imported by the controller, the datapath and the top level.
package sbh_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic        start_message;
    logic        end_message;
  } sbh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } sbh_out_t;

  typedef struct packed {
    logic       load_word;
    logic       reload_iv;
    logic       init_vars;
    logic       round;
    logic [5:0] round_idx;
    logic       update;
    logic       load_digest;
    logic       shift_digest;
  } sbh_cmd_t;

  localparam logic [31:0] IV_TABLE [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* rtl/core/sha256_block_hasher.sv */
// SHA-256 block hasher: a padded message goes in as 32-bit big-endian words and
// leaves as eight digest words, H0 first, after the block that carries end_message.
// Each block of 16 words is taken at one word per cycle, then the single round unit
// runs the 64 rounds at one round per cycle, then adds the result into the chaining
// words. No word is taken during the rounds. The digest drains from its own buffer,
// so the next message loads while it waits; a final block whose digest is ready holds
// its chain update until the previous digest has fully left.
// Depends on sbh_pkg, sbh_ctrl and sbh_datapath.
module sha256_block_hasher (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sbh_pkg::sbh_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sbh_pkg::sbh_out_t out_data
);
  import sbh_pkg::*;

  sbh_cmd_t    cmd;
  logic        digest_last;
  logic [31:0] digest_word;

  sbh_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_last (digest_last),
    .cmd         (cmd)
  );

  sbh_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_data.message_word),
    .out_word (digest_word)
  );

  always_comb begin
    out_data.digest_word = digest_word;
    out_data.digest_last = digest_last;
  end

endmodule

/* rtl/core/sbh_ctrl.sv */
// Controller of the SHA-256 block hasher: word counting, round sequencing, digest handshake.
// Depends on sbh_pkg; drives sbh_datapath through sbh_cmd_t.
module sbh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  sbh_pkg::sbh_in_t in_data,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             digest_last,
  output sbh_pkg::sbh_cmd_t cmd
);
  import sbh_pkg::*;

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_ROUND  = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  localparam logic [3:0] LAST_POS   = 4'd15;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_OUT   = 3'd7;

  logic [1:0] state_r, state_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [5:0] round_r, round_nxt;
  logic       end_r, end_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_cnt_r, out_cnt_nxt;

  logic       in_acc;
  logic [3:0] eff_pos;
  logic       update_go;
  logic       out_acc;

  assign in_ready    = (state_r == ST_LOAD);
  assign in_acc      = in_valid & in_ready;
  assign eff_pos     = in_data.start_message ? 4'd0 : pos_r;
  assign update_go   = (state_r == ST_UPDATE) & ~(end_r & out_valid_r);
  assign out_acc     = out_valid_r & out_ready;
  assign out_valid   = out_valid_r;
  assign digest_last = (out_cnt_r == LAST_OUT);

  always_comb begin
    cmd.load_word    = in_acc;
    cmd.reload_iv    = in_acc & in_data.start_message;
    cmd.init_vars    = in_acc & (eff_pos == LAST_POS);
    cmd.round        = (state_r == ST_ROUND);
    cmd.round_idx    = round_r;
    cmd.update       = update_go;
    cmd.load_digest  = update_go & end_r;
    cmd.shift_digest = out_acc;
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    round_nxt = round_r;
    end_nxt   = end_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          pos_nxt = eff_pos + 4'd1;
          if (eff_pos == LAST_POS) begin
            state_nxt = ST_ROUND;
            round_nxt = '0;
            end_nxt   = in_data.end_message;
          end
        end
      end
      ST_ROUND: begin
        round_nxt = round_r + 6'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (update_go) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cnt_nxt   = out_cnt_r;
    priority if (cmd.load_digest) begin
      out_valid_nxt = 1'b1;
      out_cnt_nxt   = '0;
    end else if (out_acc) begin
      out_cnt_nxt = out_cnt_r + 3'd1;
      if (out_cnt_r == LAST_OUT) begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      pos_r       <= '0;
      round_r     <= '0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      round_r     <= round_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
      out_cnt_r   <= out_cnt_nxt;
    end
  end

  a_block_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init_vars |=> (state_r == ST_ROUND) && (round_r == 6'd0))
    else $error("completed block did not start the round sequence");

  a_update_after_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) && ($past(state_r) == ST_ROUND) |-> ($past(round_r) == LAST_ROUND))
    else $error("chain update entered before the last round");

  a_digest_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_digest |-> !out_valid_r)
    else $error("digest buffer reloaded while words still pending");

  a_digest_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_acc && (out_cnt_r == LAST_OUT)))
    else $error("digest stream ended before its eighth word");

endmodule

/* rtl/core/sbh_datapath.sv */
// Datapath of the SHA-256 block hasher: schedule shift line, round logic, chain and digest words.
// Depends on sbh_pkg; steered by sbh_ctrl through sbh_cmd_t.
module sbh_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  sbh_pkg::sbh_cmd_t cmd,
  input  logic [31:0]       in_word,
  output logic [31:0]       out_word
);
  import sbh_pkg::*;

  logic [31:0] w_r     [16];
  logic [31:0] v_r     [8];
  logic [31:0] chain_r [8];
  logic [31:0] dig_r   [8];

  logic [31:0] w_new;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] chain_sum [8];

  // W[t+16] from the window W[t]..W[t+15] held in w_r
  assign w_new = w_r[0] + small_sigma0(w_r[1]) + w_r[9] + small_sigma1(w_r[14]);

  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + big_sigma1(v_r[4]) + ch + K_TABLE[cmd.round_idx] + w_r[0];
  assign t2  = big_sigma0(v_r[0]) + maj;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_sum[i] = chain_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word || cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= cmd.load_word ? in_word : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_vars) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= chain_r[i];
      end
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reload_iv) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= IV_TABLE[i];
      end
    end else if (cmd.update) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_sum[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_digest) begin
      for (int i = 0; i < 8; i++) begin
        dig_r[i] <= chain_sum[i];
      end
    end else if (cmd.shift_digest) begin
      for (int i = 0; i < 7; i++) begin
        dig_r[i] <= dig_r[i+1];
      end
      dig_r[7] <= dig_r[7];
    end
  end

  assign out_word = dig_r[0];

endmodule
